### sv/bcm_pkg.sv
// Package for the one-RC battery cell model block.
// Holds shared constants, register indexes and the saturation helper.
// No dependencies.
`default_nettype none
package bcm_pkg;

  localparam int TBL_DEPTH = 128;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int ROW_W     = 96;

  localparam logic        MODE_LOAD = 1'b0;
  localparam logic        MODE_EVAL = 1'b1;

  localparam logic [1:0]  CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0]  CFG_CAPACITY      = 2'd1;
  localparam logic [1:0]  CFG_TABLE_LENGTH  = 2'd2;

  localparam logic signed [31:0] Q24_ONE = 32'sd16777216;

  typedef logic signed [31:0] q24_t;
  typedef logic signed [65:0] acc_t;

  // Saturate a wide signed value to the signed 32 bit range.
  function automatic q24_t sat32(input acc_t v);
    q24_t r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/bcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the breakpoint table rows. No dependencies.
`default_nettype none
module bcm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### sv/battery_cell_model_step_top.sv
// Top level of the one-RC battery cell model, Q8.24 fixed point.
// Depends on bcm_pkg and bcm_ram.
`default_nettype none
// Usage
//   Input channel (in_*): one beat per item. mode 0 loads one table row
//   (SOC, OCV, OCV slope); mode 1 evaluates the model for the given state.
//   Output channel (out_*): exactly one result beat per input beat, in order.
//   Load beats return all-zero fields.
//   Config channel (cfg_*): always ready; write only while the block is idle.
//   Index 0 sample period, 1 capacity, 2 table length; index 3 is dropped.
// Sequencing
//   One item at a time. A load beat is answered the next cycle. An evaluate
//   beat walks the SOC table one row at a time (a read state, then a compare
//   state) through the single RAM read port. It uses one shared restoring
//   divider (56 steps for the interpolation fraction, 39 steps for the Coulomb
//   count) and one shared 34x34 multiplier (six products; where no interpolation
//   is needed, the fraction divide and its two products are skipped).
// Reset
//   Synchronous, active low. Restores config defaults, empties the output
//   register. Table contents are undefined until loaded.
// Stall
//   A finished result holds in the output register; hold input ready low
//   until the output register is free.
module battery_cell_model_step_top
  import bcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [6:0]  in_row_index,
  input  wire logic signed [31:0] in_row_soc,
  input  wire logic signed [31:0] in_row_ocv,
  input  wire logic signed [31:0] in_row_slope,
  input  wire logic signed [31:0] in_soc_now,
  input  wire logic signed [31:0] in_rc_voltage_now,
  input  wire logic signed [31:0] in_current,
  input  wire logic signed [31:0] in_series_resistance,
  input  wire logic signed [31:0] in_rc_pole,
  input  wire logic signed [31:0] in_rc_gain,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_terminal_voltage,
  output logic [24:0]      out_soc_next,
  output logic signed [31:0] out_rc_voltage_next,
  output logic signed [31:0] out_ocv_slope,
  output logic [2:0]       out_clamp_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_R0   = 5'd1;
  localparam logic [4:0] S_C0   = 5'd2;
  localparam logic [4:0] S_RL   = 5'd3;
  localparam logic [4:0] S_CL   = 5'd4;
  localparam logic [4:0] S_RS   = 5'd5;
  localparam logic [4:0] S_CS   = 5'd6;
  localparam logic [4:0] S_RA   = 5'd7;
  localparam logic [4:0] S_CA   = 5'd8;
  localparam logic [4:0] S_DIVF = 5'd9;
  localparam logic [4:0] S_MO   = 5'd10;
  localparam logic [4:0] S_MOW  = 5'd11;
  localparam logic [4:0] S_MSW  = 5'd12;
  localparam logic [4:0] S_MR   = 5'd13;
  localparam logic [4:0] S_MRW  = 5'd14;
  localparam logic [4:0] S_MQ   = 5'd15;
  localparam logic [4:0] S_DIVQ = 5'd16;
  localparam logic [4:0] S_SN   = 5'd17;
  localparam logic [4:0] S_MB   = 5'd18;
  localparam logic [4:0] S_MC   = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  // Configuration registers
  logic [30:0] sample_period_r;
  logic [19:0] capacity_r;
  logic [7:0]  table_length_r;

  logic [4:0]  state_r;
  logic        out_free;
  logic        out_set;
  logic        in_acc;

  // Latched item state
  q24_t        soc_r, v_r, u_r, r0_r, a1_r, b1_r;
  logic [2:0]  cnt_r;
  logic [TBL_AW-1:0] idx_r;
  logic [ROW_W-1:0]  rowa_r, rowb_r;
  q24_t        ocv_r, slope_r, vt_r, vn_r;
  logic [24:0] sn_r;
  acc_t        acc_r;
  logic        neg_r;

  // Shared divider
  logic [33:0] rem_r, dsr_r;
  logic [63:0] dq_r;
  logic [5:0]  dcnt_r;
  logic [33:0] div_try;
  logic        div_ge;

  // Shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p_r;
  logic signed [67:0] p_sh;
  acc_t        p66;

  // Table RAM
  logic [TBL_AW-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_data;
  logic              ram_we;

  logic [7:0]  len_eff;
  logic [TBL_AW-1:0] last_idx;
  logic [7:0]  len_m1;
  q24_t        rd_soc, rd_ocv, rd_slope;
  q24_t        ra_ocv, ra_slope, rb_ocv, rb_slope;
  logic signed [32:0] span, dx, dy_ocv, dy_slope;
  logic [7:0]  idx_p2;

  q24_t        r0_c, a1_c, b1_c;
  logic [2:0]  cnt_c;

  logic [67:0] mag;
  logic [19:0] q_eff;
  acc_t        soc_x, dd, sn_w, acc_sum;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign ram_we    = in_acc && (in_mode == MODE_LOAD);
  // Raise the result beat for a load at accept, for an evaluate when it leaves S_OUT
  assign out_set   = ((state_r == S_IDLE) && in_acc && (in_mode == MODE_LOAD)) ||
                     ((state_r == S_OUT) && out_free);

  assign len_eff  = (table_length_r > 8'(TBL_DEPTH)) ? 8'(TBL_DEPTH) : table_length_r;
  assign len_m1   = len_eff - 8'd1;
  assign last_idx = len_m1[TBL_AW-1:0];
  assign idx_p2   = {1'b0, idx_r} + 8'd2;

  assign rd_soc   = rd_data[95:64];
  assign rd_ocv   = rd_data[63:32];
  assign rd_slope = rd_data[31:0];
  assign ra_ocv   = rowa_r[63:32];
  assign ra_slope = rowa_r[31:0];
  assign rb_ocv   = rowb_r[63:32];
  assign rb_slope = rowb_r[31:0];

  // Segment geometry: row a arrives on the read port in S_CA, row b is held
  assign span     = {rowb_r[95], rowb_r[95:64]} - {rd_soc[31], rd_soc};
  assign dx       = {soc_r[31], soc_r} - {rd_soc[31], rd_soc};
  assign dy_ocv   = {rb_ocv[31], rb_ocv} - {ra_ocv[31], ra_ocv};
  assign dy_slope = {rb_slope[31], rb_slope} - {ra_slope[31], ra_slope};

  // Parameter clamps applied at accept
  always_comb begin
    r0_c  = in_series_resistance;
    a1_c  = in_rc_pole;
    b1_c  = in_rc_gain;
    cnt_c = 3'd0;
    if (in_series_resistance <= 0) begin
      r0_c  = '0;
      cnt_c = cnt_c + 3'd1;
    end
    if (in_rc_pole < 0) begin
      a1_c  = '0;
      cnt_c = cnt_c + 3'd1;
    end else if (in_rc_pole > Q24_ONE) begin
      a1_c  = Q24_ONE;
      cnt_c = cnt_c + 3'd1;
    end
    if (in_rc_gain > 0) begin
      b1_c  = '0;
      cnt_c = cnt_c + 3'd1;
    end
  end

  // RAM read address per sequencer step
  always_comb begin
    unique case (state_r)
      S_R0:    rd_addr = '0;
      S_RL:    rd_addr = last_idx;
      S_RS:    rd_addr = idx_r + 1'b1;
      default: rd_addr = idx_r;
    endcase
  end

  // Multiplier operand select
  always_comb begin
    unique case (state_r)
      S_MO: begin
        mul_a = {dy_ocv[32], dy_ocv};
        mul_b = {10'b0, dq_r[23:0]};
      end
      S_MOW: begin
        mul_a = {dy_slope[32], dy_slope};
        mul_b = {10'b0, dq_r[23:0]};
      end
      S_MR: begin
        mul_a = {{2{r0_r[31]}}, r0_r};
        mul_b = {{2{u_r[31]}}, u_r};
      end
      S_MRW: begin
        mul_a = {3'b0, sample_period_r};
        mul_b = {{2{u_r[31]}}, u_r};
      end
      S_SN: begin
        mul_a = {{2{a1_r[31]}}, a1_r};
        mul_b = {{2{v_r[31]}}, v_r};
      end
      default: begin
        mul_a = {{2{b1_r[31]}}, b1_r};
        mul_b = {{2{u_r[31]}}, u_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  assign p_sh = mul_p_r >>> 24;
  assign p66  = p_sh[65:0];

  // One restoring divide step
  assign div_try = {rem_r[32:0], dq_r[63]};
  assign div_ge  = div_try >= dsr_r;

  assign mag     = mul_p_r[67] ? 68'(-mul_p_r) : mul_p_r;
  assign q_eff   = (capacity_r == '0) ? 20'd1 : capacity_r;
  assign soc_x   = {{34{soc_r[31]}}, soc_r};
  assign dd      = {27'b0, dq_r[38:0]};
  assign sn_w    = neg_r ? (soc_x + dd) : (soc_x - dd);
  assign acc_sum = acc_r + mul_p_r[65:0];

  bcm_ram #(.WIDTH(ROW_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_row_index[TBL_AW-1:0]),
    .wr_data ({in_row_soc, in_row_ocv, in_row_slope}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= 31'd16777216;
      capacity_r      <= 20'd3960;
      table_length_r  <= 8'd101;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SAMPLE_PERIOD: sample_period_r <= cfg_data;
        CFG_CAPACITY:      capacity_r      <= cfg_data[19:0];
        CFG_TABLE_LENGTH:  table_length_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      dcnt_r    <= '0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_mode == MODE_EVAL) state_r <= S_R0;
        end
        S_R0: state_r <= S_C0;
        S_C0: begin
          if (len_eff < 8'd2 || soc_r <= rd_soc) state_r <= S_MR;
          else state_r <= S_RL;
        end
        S_RL: state_r <= S_CL;
        S_CL: begin
          if (soc_r >= rd_soc) state_r <= S_MR;
          else state_r <= S_RS;
        end
        S_RS: state_r <= S_CS;
        S_CS: begin
          if (idx_p2 < len_eff && soc_r >= rd_soc) state_r <= S_RS;
          else state_r <= S_RA;
        end
        S_RA: state_r <= S_CA;
        S_CA: begin
          if (span <= 0 || dx < 0 || dx >= span) begin
            state_r <= S_MR;
          end else begin
            state_r <= S_DIVF;
            dcnt_r  <= 6'd56;
          end
        end
        S_DIVF: begin
          dcnt_r <= dcnt_r - 6'd1;
          if (dcnt_r == 6'd1) state_r <= S_MO;
        end
        S_MO:  state_r <= S_MOW;
        S_MOW: state_r <= S_MSW;
        S_MSW: state_r <= S_MR;
        S_MR:  state_r <= S_MRW;
        S_MRW: state_r <= S_MQ;
        S_MQ: begin
          state_r <= S_DIVQ;
          dcnt_r  <= 6'd39;
        end
        S_DIVQ: begin
          dcnt_r <= dcnt_r - 6'd1;
          if (dcnt_r == 6'd1) state_r <= S_SN;
        end
        S_SN: state_r <= S_MB;
        S_MB: state_r <= S_MC;
        S_MC: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          soc_r <= in_soc_now;
          v_r   <= in_rc_voltage_now;
          u_r   <= in_current;
          r0_r  <= r0_c;
          a1_r  <= a1_c;
          b1_r  <= b1_c;
          cnt_r <= cnt_c;
          if (in_mode == MODE_LOAD) begin
            out_terminal_voltage <= '0;
            out_soc_next         <= '0;
            out_rc_voltage_next  <= '0;
            out_ocv_slope        <= '0;
            out_clamp_count      <= '0;
          end
        end
      end
      S_C0: begin
        ocv_r   <= rd_ocv;
        slope_r <= rd_slope;
      end
      S_CL: begin
        ocv_r   <= rd_ocv;
        slope_r <= rd_slope;
        idx_r   <= '0;
      end
      S_CS: begin
        if (idx_p2 < len_eff && soc_r >= rd_soc) idx_r <= idx_r + 1'b1;
        else rowb_r <= rd_data;
      end
      S_CA: begin
        rowa_r  <= rd_data;
        ocv_r   <= rd_ocv;
        slope_r <= rd_slope;
        rem_r   <= '0;
        dsr_r   <= {1'b0, span};
        dq_r    <= {dx[31:0], 32'b0};
      end
      S_DIVF, S_DIVQ: begin
        rem_r <= div_ge ? (div_try - dsr_r) : div_try;
        dq_r  <= {dq_r[62:0], div_ge};
      end
      S_MOW: ocv_r   <= sat32({{34{ra_ocv[31]}}, ra_ocv} + p66);
      S_MSW: slope_r <= sat32({{34{ra_slope[31]}}, ra_slope} + p66);
      S_MRW: vt_r    <= sat32({{34{ocv_r[31]}}, ocv_r} - p66 + {{34{v_r[31]}}, v_r});
      S_MQ: begin
        // floor(|p| / 2^24) / q equals the truncated quotient of |p| by q*2^24
        neg_r <= mul_p_r[67];
        rem_r <= '0;
        dsr_r <= {14'b0, q_eff};
        dq_r  <= {mag[62:24], 25'b0};
      end
      S_SN: begin
        // Signed compares: a negative SOC goes to empty, never to full
        if (sn_w > acc_t'(Q24_ONE)) begin
          sn_r  <= Q24_ONE[24:0];
          cnt_r <= cnt_r + 3'd1;
        end else if (sn_w < 0) begin
          sn_r  <= '0;
          cnt_r <= cnt_r + 3'd1;
        end else begin
          sn_r  <= sn_w[24:0];
        end
      end
      S_MB: acc_r <= mul_p_r[65:0];
      S_MC: vn_r  <= sat32(acc_sum >>> 24);
      S_OUT: begin
        if (out_free) begin
          out_terminal_voltage <= vt_r;
          out_soc_next         <= sn_r;
          out_rc_voltage_next  <= vn_r;
          out_ocv_slope        <= slope_r;
          out_clamp_count      <= cnt_r;
        end
      end
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("input ready outside idle");

  a_div_states: assert property (@(posedge clk) disable iff (!rst_n)
    (dcnt_r != 6'd0) |-> (state_r == S_DIVF || state_r == S_DIVQ))
    else $error("divider count live outside divide states");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == MODE_LOAD) |=>
      (out_valid && out_clamp_count == 3'd0 && out_soc_next == 25'd0))
    else $error("load beat did not produce a zero result");

endmodule
`default_nettype wire

### dv/battery_cell_model_step_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for battery_cell_model_step_top: loads table rows,
// evaluates the one-RC cell model and checks every result beat against a
// built-in fixed-point predictor. Depends on bcm_pkg and the block's RTL.
module battery_cell_model_step_top_tb
  import bcm_pkg::*;
();

  localparam longint     ONE_Q      = 64'sd16777216;
  localparam int         WDOG_LIMIT = 5000;
  localparam int         SOC_BASE   = -(1 << 21);
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  typedef struct {
    bit        mode;
    bit [6:0]  row;
    int        rsoc, rocv, rslope;
    int        soc, v, u, r0, a1, b1;
  } cell_item_t;

  typedef struct {
    int        vt;
    bit [24:0] soc_n;
    int        vn;
    int        slope;
    bit [2:0]  clamps;
  } cell_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [6:0] in_row_index = '0;
  logic signed [31:0] in_row_soc = '0, in_row_ocv = '0, in_row_slope = '0;
  logic signed [31:0] in_soc_now = '0, in_rc_voltage_now = '0, in_current = '0;
  logic signed [31:0] in_series_resistance = '0, in_rc_pole = '0, in_rc_gain = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_terminal_voltage, out_rc_voltage_next, out_ocv_slope;
  logic [24:0] out_soc_next;
  logic [2:0]  out_clamp_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  battery_cell_model_step_top dut (.*);

  // Predictor state: shadow registers and breakpoint tables.
  bit [30:0] period_reg = 31'd16777216;
  bit [19:0] capacity_reg = 20'd3960;
  bit [7:0]  length_reg = 8'd101;
  int        soc_tbl[TBL_DEPTH];
  int        ocv_tbl[TBL_DEPTH];
  int        slope_tbl[TBL_DEPTH];

  cell_item_t   pending_q[$];
  cell_result_t cell_result_q[$];
  cell_item_t   drv_item;
  bit           in_taken = 0;
  bit           quiet = 0;
  int           in_gap = 0, out_gap = 0;
  int           errors = 0, n_loads = 0, n_evals = 0, n_settings = 1;
  int           idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint row_value(bit use_slope, int i);
    return use_slope ? longint'(slope_tbl[i]) : longint'(ocv_tbl[i]);
  endfunction

  // Piecewise-linear lookup over the SOC breakpoints, clamped at the ends.
  function automatic longint interp_row(bit use_slope, longint x);
    int     len;
    int     i;
    longint x0, x1, y0, y1, span, dx, frac;
    len = (length_reg > TBL_DEPTH) ? TBL_DEPTH : int'(length_reg);
    if (len < 2) return row_value(use_slope, 0);
    if (x <= soc_tbl[0]) return row_value(use_slope, 0);
    if (x >= soc_tbl[len-1]) return row_value(use_slope, len - 1);
    i = 0;
    while (i + 2 < len && !(x < soc_tbl[i+1])) i++;
    x0 = soc_tbl[i];
    x1 = soc_tbl[i+1];
    y0 = row_value(use_slope, i);
    y1 = row_value(use_slope, i + 1);
    span = x1 - x0;
    dx = x - x0;
    if (span <= 0 || dx < 0 || dx >= span) return y0;
    frac = (dx <<< 24) / span;
    return clip32(y0 + (((y1 - y0) * frac) >>> 24));
  endfunction

  function automatic cell_result_t predict_cell_step(cell_item_t it);
    cell_result_t r;
    longint soc, v, u, r0, a1, b1, ocv, q, delta, soc_n;
    r = '{default: 0};
    if (it.mode == MODE_LOAD) begin
      soc_tbl[it.row] = it.rsoc;
      ocv_tbl[it.row] = it.rocv;
      slope_tbl[it.row] = it.rslope;
      return r;
    end
    soc = it.soc; v = it.v; u = it.u;
    r0 = it.r0; a1 = it.a1; b1 = it.b1;
    if (r0 <= 0) begin r0 = 0; r.clamps++; end
    if (a1 < 0) begin
      a1 = 0; r.clamps++;
    end else if (a1 > ONE_Q) begin
      a1 = ONE_Q; r.clamps++;
    end
    if (b1 > 0) begin b1 = 0; r.clamps++; end
    ocv = interp_row(0, soc);
    r.slope = int'(interp_row(1, soc));
    r.vt = int'(clip32(ocv - ((r0 * u) >>> 24) + v));
    q = (capacity_reg == 0) ? 1 : longint'(capacity_reg);
    delta = (longint'(period_reg) * u) / (q * ONE_Q);
    soc_n = soc - delta;
    if (soc_n > ONE_Q) begin
      soc_n = ONE_Q; r.clamps++;
    end else if (soc_n < 0) begin
      soc_n = 0; r.clamps++;
    end
    r.soc_n = soc_n[24:0];
    r.vn = int'(clip32((a1 * v + b1 * u) >>> 24));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: present the next pending beat at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        in_taken = 0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          drv_item = pending_q.pop_front();
          in_mode <= drv_item.mode;
          in_row_index <= drv_item.row;
          in_row_soc <= drv_item.rsoc;
          in_row_ocv <= drv_item.rocv;
          in_row_slope <= drv_item.rslope;
          in_soc_now <= drv_item.soc;
          in_rc_voltage_now <= drv_item.v;
          in_current <= drv_item.u;
          in_series_resistance <= drv_item.r0;
          in_rc_pole <= drv_item.a1;
          in_rc_gain <= drv_item.b1;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(9) == 0) in_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Stall the result channel in random bursts.
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(7) == 0) out_gap = $urandom_range(1, 11);
      end
    end
  end

  // Monitor: predict on each input beat, check each result beat, watch for hangs.
  always @(posedge clk) begin
    cell_result_t want;
    bit busy;
    if (rst_n) begin
      busy = 0;
      if (in_valid && in_ready) begin
        cell_result_q.push_back(predict_cell_step(drv_item));
        if (drv_item.mode == MODE_LOAD) n_loads++;
        else n_evals++;
        in_taken = 1;
        busy = 1;
      end
      if (out_valid && out_ready) begin
        busy = 1;
        if (cell_result_q.size() == 0) begin
          $display("[%0t] result beat with nothing expected", $realtime);
          errors++;
        end else begin
          want = cell_result_q.pop_front();
          if (out_terminal_voltage !== want.vt)
            report_mismatch("terminal_voltage", out_terminal_voltage, want.vt);
          if (out_soc_next !== want.soc_n)
            report_mismatch("soc_next", out_soc_next, want.soc_n);
          if (out_rc_voltage_next !== want.vn)
            report_mismatch("rc_voltage_next", out_rc_voltage_next, want.vn);
          if (out_ocv_slope !== want.slope)
            report_mismatch("ocv_slope", out_ocv_slope, want.slope);
          if (out_clamp_count !== want.clamps)
            report_mismatch("clamp_count", out_clamp_count, want.clamps);
        end
      end
      if (cfg_valid && cfg_ready) busy = 1;
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Timeout: no beat accepted for %0d cycles", WDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Write one register and mirror it into the predictor on acceptance.
  task automatic write_reg(logic [1:0] idx, logic [30:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SAMPLE_PERIOD: period_reg = value;
      CFG_CAPACITY:      capacity_reg = value[19:0];
      CFG_TABLE_LENGTH:  length_reg = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every beat went in and every result came back, then settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || cell_result_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic int any_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int rows_in_use();
    int le;
    le = (length_reg > TBL_DEPTH) ? TBL_DEPTH : int'(length_reg);
    return (le < 2) ? 2 : le;
  endfunction

  function automatic int soc_step();
    return (18 << 20) / (rows_in_use() - 1);
  endfunction

  function automatic int breakpoint(int i);
    int le;
    le = rows_in_use();
    if (i < le) return SOC_BASE + i * soc_step();
    return SOC_BASE + (le - 1) * soc_step() + (i - le + 1);
  endfunction

  task automatic push_row(int i, bit wild);
    cell_item_t it;
    it = '{default: 0};
    it.mode = MODE_LOAD;
    it.row = 7'(i);
    // Payload fields unused by a load still carry noise.
    it.soc = int'($urandom); it.u = int'($urandom); it.a1 = int'($urandom);
    if (wild) begin
      it.rsoc = any_word(); it.rocv = any_word(); it.rslope = any_word();
    end else begin
      it.rsoc = breakpoint(i);
      it.rocv = int'(64'sd50331648 + longint'(i) * (20132659 / (rows_in_use() - 1))
                     + $urandom_range(4095));
      it.rslope = ($urandom_range(9) == 0) ? any_word() : int'($urandom_range(1 << 26));
    end
    pending_q.push_back(it);
  endtask

  task automatic push_eval(int soc, int v, int u, int r0, int a1, int b1);
    cell_item_t it;
    it = '{default: 0};
    it.mode = MODE_EVAL;
    it.row = 7'($urandom_range(127));
    it.rsoc = int'($urandom); it.rocv = int'($urandom); it.rslope = int'($urandom);
    it.soc = soc; it.v = v; it.u = u; it.r0 = r0; it.a1 = a1; it.b1 = b1;
    pending_q.push_back(it);
  endtask

  // Load every row that the current table length reads.
  task automatic fill_table(bit wild);
    int n;
    n = rows_in_use();
    for (int i = 0; i < n; i++) push_row(i, wild);
  endtask

  // Mostly plausible operating points, with full-range noise mixed in.
  task automatic add_random_items(int n, bit wild);
    int lo, hi, soc, v, u, r0, a1, b1;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        push_row($urandom_range(127), wild);
      end else begin
        lo = SOC_BASE - (1 << 20);
        hi = breakpoint(rows_in_use() - 1) + (1 << 20);
        case ($urandom_range(9))
          0: soc = any_word();
          1, 2: soc = breakpoint($urandom_range(rows_in_use() - 1));
          default: soc = lo + int'($urandom_range(hi - lo));
        endcase
        v  = ($urandom_range(9) == 0) ? any_word() : int'($urandom_range(3355443)) - 1677721;
        u  = ($urandom_range(9) == 0) ? any_word()
                                      : int'($urandom_range(671088640)) - 335544320;
        r0 = ($urandom_range(9) == 0) ? any_word() : int'($urandom_range(1 << 21));
        a1 = ($urandom_range(9) == 0) ? any_word() : int'($urandom_range(1 << 24));
        b1 = ($urandom_range(9) == 0) ? any_word() : -int'($urandom_range(1 << 22));
        push_eval(wild ? any_word() : soc, v, u, r0, a1, b1);
      end
    end
  endtask

  task automatic run_setting(int period, int capacity, int length, bit wild, int n);
    write_reg(CFG_SAMPLE_PERIOD, 31'(period));
    write_reg(CFG_CAPACITY, 31'(capacity));
    write_reg(CFG_TABLE_LENGTH, 31'(length));
    n_settings++;
    fill_table(wild);
    add_random_items(n, wild);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass on the reset configuration (101 rows, 1 s, 3960 As).
    fill_table(0);
    push_eval(32'h8000_0000, 0, 1 << 24, 0, -1, 1);             // below table, all params clamp
    push_eval(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);     // above table, extremes
    push_eval(breakpoint(0), 1000, 1 << 24, 1, 1 << 24, 0);     // first breakpoint, no parameter clamps
    push_eval(breakpoint(50), -1000, -(1 << 24), 1 << 20, (1 << 24) + 1, -5);
    push_eval(breakpoint(50) + 1000, 0, 0, 1 << 20, 1 << 23, -(1 << 20));
    push_eval(breakpoint(100), 0, 0, 1 << 20, 1 << 23, -1);     // last breakpoint
    push_eval(1 << 24, 0, 32'h8000_0000, 1 << 20, 0, 0);        // charge past full
    push_eval(0, 0, 32'h7fff_ffff, 1 << 20, 0, 0);              // discharge below empty
    push_eval(1 << 23, 32'h7fff_ffff, 32'h8000_0000, 1 << 20,
              1 << 24, 32'h8000_0000);                          // RC voltage saturates high
    push_eval(1 << 23, 32'h8000_0000, 32'h7fff_ffff, 1 << 20,
              1 << 24, 32'h8000_0000);                          // RC voltage saturates low
    push_eval(1 << 23, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              0, 0);                                            // terminal voltage saturates
    push_row(127, 1);
    push_row(0, 0);
    add_random_items(100, 0);
    wait_drained();

    run_setting(1 << 24, 3960, 2, 0, 100);
    run_setting(32'h7fff_ffff, 1, 128, 0, 150);
    run_setting(0, 1048575, 5, 0, 100);
    run_setting(int'($urandom_range(1 << 26)), 0, 0, 0, 80);   // zero capacity, empty table
    run_setting(int'($urandom_range(1 << 26)), int'($urandom_range(1, 20000)), 1, 0, 80);
    write_reg(CFG_SPARE, 31'h5555_5555);                       // unused index, drop it
    run_setting(int'($urandom), int'($urandom_range(1, 1048575)), 255, 1, 100);
    run_setting(int'($urandom_range(1 << 27)), int'($urandom_range(100, 9000)), 200, 0, 100);

    // Closing stretch: no stalls on either side.
    quiet = 1;
    run_setting(1 << 24, 3960, 16, 0, 150);

    repeat (50) @(posedge clk);
    $display("Covered %0d row loads and %0d evaluations over %0d register settings,",
             n_loads, n_evals, n_settings);
    $display("including clamped parameters, saturation and out-of-range table lengths.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/bcm_pkg.sv
sv/bcm_ram.sv
sv/battery_cell_model_step_top.sv
dv/battery_cell_model_step_top_tb.sv
